/* design/hrbt_pkg.sv */
// Package for the HTTP request byte tokenizer.
// Holds the parse phase type, byte class and status codes, character constants
// and the content-length key lookup. No dependencies.
`timescale 1ns / 1ps

package hrbt_pkg;

  // Width of the length register, the length counters and the length limit
  localparam int LENGTH_BITS = 20;
  // Width of the multiply-by-ten result before the range check
  localparam int LEN_EXT_W   = LENGTH_BITS + 4;
  // Output tdata: byte_value, parse_status, method_is_get, declared_length
  localparam int OUT_BITS    = 8 + 2 + 1 + LENGTH_BITS;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int KEY_LEN     = 14;

  typedef enum logic [4:0] {
    PH_START     = 5'd0,
    PH_METHOD    = 5'd1,
    PH_METHOD_SP = 5'd2,
    PH_PATH      = 5'd3,
    PH_QKEY      = 5'd4,
    PH_QVAL      = 5'd5,
    PH_URL_SP    = 5'd6,
    PH_VERSION   = 5'd7,
    PH_VER_LF    = 5'd8,
    PH_HDR_START = 5'd9,
    PH_HKEY      = 5'd10,
    PH_HKEY_SP   = 5'd11,
    PH_HVAL      = 5'd12,
    PH_HVAL_LF   = 5'd13,
    PH_HDRS_LF   = 5'd14,
    PH_BODY      = 5'd15,
    PH_DONE      = 5'd16,
    PH_ERROR     = 5'd17
  } phase_e;

  // Byte classes
  localparam logic [3:0] CLS_DELIM  = 4'd0;
  localparam logic [3:0] CLS_METHOD = 4'd1;
  localparam logic [3:0] CLS_PATH   = 4'd2;
  localparam logic [3:0] CLS_QKEY   = 4'd3;
  localparam logic [3:0] CLS_QVAL   = 4'd4;
  localparam logic [3:0] CLS_VER    = 4'd5;
  localparam logic [3:0] CLS_HKEY   = 4'd6;
  localparam logic [3:0] CLS_HVAL   = 4'd7;
  localparam logic [3:0] CLS_BODY   = 4'd8;

  // Parse status
  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // Method match position meaning "not GET"
  localparam logic [2:0] MM_MISS = 3'd7;
  localparam logic [2:0] MM_FULL = 3'd3;

  // Characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_T     = 8'h54;

  // Lowercase "content-length", one character per position
  function automatic logic [7:0] cl_key_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h63; // c
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h6C; // l
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // GET spelled one character per match position
  function automatic logic [7:0] get_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = CH_G;
      2'd1:    c = CH_E;
      2'd2:    c = CH_T;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* design/http_request_byte_tokenizer.sv */
// HTTP request byte tokenizer: classifies each request byte and tracks status.
// Each result is registered and becomes valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the output register is refilled in the cycle
// it is drained, so the stream only stalls while the result side stalls.
// Reset (rst_ni low, asynchronous): parser returns to expecting a method,
// the length limit returns to 65536 and the output register empties.
// Depends on hrbt_pkg.
`timescale 1ns / 1ps

module http_request_byte_tokenizer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Request bytes in
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // [7:0] data_byte
  input  logic [0:0]                          s_axis_tuser,  // [0] start_new
  // Classified bytes out
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] byte_value, [9:8] parse_status, [10] method_is_get,
  // [11 +: LENGTH_BITS] declared_length, rest zero
  output logic [hrbt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic [3:0]                          m_axis_tuser,  // [3:0] byte_class
  // Length limit write
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hrbt_pkg::LENGTH_BITS-1:0]    cfg_data_i
);
  import hrbt_pkg::*;

  localparam logic [LENGTH_BITS-1:0] MAX_LEN_RST = LENGTH_BITS'(65536);

  // Parser state
  phase_e                   phase_q, phase_d;
  logic [2:0]               mpos_q, mpos_d;
  logic                     get_q, get_d;
  logic [3:0]               kpos_q, kpos_d;
  logic                     kok_q, kok_d;
  logic [LENGTH_BITS-1:0]   len_q, len_d;
  logic                     seen_q, seen_d;
  logic                     bad_q, bad_d;
  logic [LENGTH_BITS-1:0]   bcnt_q, bcnt_d;
  logic [LENGTH_BITS-1:0]   max_len_q;

  // Output register
  logic                     out_valid_q;
  logic [7:0]               out_byte_q;
  logic [3:0]               out_cls_q;
  logic [1:0]               out_st_q;
  logic                     out_get_q;
  logic [LENGTH_BITS-1:0]   out_len_q;

  // Current state as seen by this byte (start_new clears it first)
  phase_e                   cur_phase;
  logic [2:0]               cur_mpos;
  logic                     cur_get;
  logic [3:0]               cur_kpos;
  logic                     cur_kok;
  logic [LENGTH_BITS-1:0]   cur_len;
  logic                     cur_seen;
  logic                     cur_bad;
  logic [LENGTH_BITS-1:0]   cur_bcnt;

  logic                     accept;
  logic [7:0]               b;
  logic                     is_upper, is_digit, is_sp, is_cr, is_lf;
  logic [7:0]               lc_b;
  logic                     key_hit, key_hit0, key_end_ok;
  logic [LEN_EXT_W-1:0]     len_ext, len_next;
  logic                     len_over;
  logic [LENGTH_BITS-1:0]   bcnt_inc;
  logic                     body_end;
  logic                     err;
  logic [3:0]               cls;
  logic [1:0]               status;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Apply start_new ahead of the byte
  always_comb begin
    if (s_axis_tuser[0]) begin
      cur_phase = PH_START;
      cur_mpos  = '0;
      cur_get   = 1'b0;
      cur_kpos  = '0;
      cur_kok   = 1'b0;
      cur_len   = '0;
      cur_seen  = 1'b0;
      cur_bad   = 1'b0;
      cur_bcnt  = '0;
    end else begin
      cur_phase = phase_q;
      cur_mpos  = mpos_q;
      cur_get   = get_q;
      cur_kpos  = kpos_q;
      cur_kok   = kok_q;
      cur_len   = len_q;
      cur_seen  = seen_q;
      cur_bad   = bad_q;
      cur_bcnt  = bcnt_q;
    end
  end

  // Byte decode
  assign b        = s_axis_tdata;
  assign is_upper = (b >= CH_UA) && (b <= CH_UZ);
  assign is_digit = (b >= CH_0) && (b <= CH_9);
  assign is_sp    = (b == CH_SP);
  assign is_cr    = (b == CH_CR);
  assign is_lf    = (b == CH_LF);
  assign lc_b     = is_upper ? (b + 8'd32) : b;

  // Header key matching against content-length
  assign key_hit    = cur_kok && (cur_kpos < 4'(KEY_LEN)) && (lc_b == cl_key_char(cur_kpos));
  assign key_hit0   = (lc_b == cl_key_char(4'd0));
  assign key_end_ok = cur_kok && (cur_kpos == 4'(KEY_LEN));

  // Decimal accumulate: len * 10 + digit
  assign len_ext  = {4'b0, cur_len};
  assign len_next = (len_ext << 3) + (len_ext << 1) + LEN_EXT_W'(b[3:0]);
  assign len_over = len_next > {4'b0, max_len_q};

  // Body byte count
  assign bcnt_inc = cur_bcnt + 1'b1;
  assign body_end = bcnt_inc >= cur_len;

  // Class, status and error for this byte
  always_comb begin
    cls    = CLS_DELIM;
    status = ST_BUSY;
    err    = 1'b0;
    case (cur_phase)
      PH_START: begin
        if (is_upper) cls = CLS_METHOD;
        else err = 1'b1;
      end
      PH_METHOD: begin
        if (is_upper) cls = CLS_METHOD;
        else if (!is_sp) err = 1'b1;
      end
      PH_METHOD_SP: begin
        if (is_sp) err = 1'b1;
        else if (b != CH_QUEST) cls = CLS_PATH;
      end
      PH_PATH: begin
        if (!is_sp && b != CH_QUEST) cls = CLS_PATH;
      end
      PH_QKEY: begin
        if (b != CH_EQ) cls = CLS_QKEY;
      end
      PH_QVAL: begin
        if (b != CH_AMP && !is_sp) cls = CLS_QVAL;
      end
      PH_URL_SP: begin
        if (is_sp) err = 1'b1;
        else if (!is_cr) cls = CLS_VER;
      end
      PH_VERSION: begin
        if (!is_cr) cls = CLS_VER;
      end
      PH_VER_LF: begin
        if (!is_lf) err = 1'b1;
      end
      PH_HDR_START: begin
        if (!is_cr && b != CH_COLON) cls = CLS_HKEY;
      end
      PH_HKEY: begin
        if (b != CH_COLON) cls = CLS_HKEY;
      end
      PH_HKEY_SP: begin
        if (!is_sp) err = 1'b1;
      end
      PH_HVAL: begin
        if (!is_cr) cls = CLS_HVAL;
      end
      PH_HVAL_LF: begin
        if (!is_lf) err = 1'b1;
      end
      PH_HDRS_LF: begin
        if (!is_lf) err = 1'b1;
        else if (cur_get) status = ST_DONE;
        else if (!cur_seen || cur_bad) err = 1'b1;
        else if (cur_len == '0) status = ST_DONE;
      end
      PH_BODY: begin
        cls = CLS_BODY;
        if (body_end) status = ST_DONE;
      end
      default: begin
        err = 1'b1;
      end
    endcase
    if (err) begin
      cls    = CLS_DELIM;
      status = ST_ERR;
    end
  end

  // Next parser state
  always_comb begin
    phase_d = cur_phase;
    mpos_d  = cur_mpos;
    get_d   = cur_get;
    kpos_d  = cur_kpos;
    kok_d   = cur_kok;
    len_d   = cur_len;
    seen_d  = cur_seen;
    bad_d   = cur_bad;
    bcnt_d  = cur_bcnt;
    case (cur_phase)
      PH_START: begin
        if (is_upper) begin
          mpos_d  = (b == CH_G) ? 3'd1 : MM_MISS;
          phase_d = PH_METHOD;
        end
      end
      PH_METHOD: begin
        if (is_upper) begin
          if (cur_mpos < MM_FULL && b == get_char(cur_mpos[1:0])) mpos_d = cur_mpos + 3'd1;
          else mpos_d = MM_MISS;
        end else if (is_sp) begin
          get_d   = (cur_mpos == MM_FULL);
          phase_d = PH_METHOD_SP;
        end
      end
      PH_METHOD_SP: begin
        if (b == CH_QUEST) phase_d = PH_QKEY;
        else if (!is_sp) phase_d = PH_PATH;
      end
      PH_PATH: begin
        if (is_sp) phase_d = PH_URL_SP;
        else if (b == CH_QUEST) phase_d = PH_QKEY;
      end
      PH_QKEY: begin
        if (b == CH_EQ) phase_d = PH_QVAL;
      end
      PH_QVAL: begin
        if (b == CH_AMP) phase_d = PH_QKEY;
        else if (is_sp) phase_d = PH_URL_SP;
      end
      PH_URL_SP: begin
        if (is_cr) phase_d = PH_VER_LF;
        else if (!is_sp) phase_d = PH_VERSION;
      end
      PH_VERSION: begin
        if (is_cr) phase_d = PH_VER_LF;
      end
      PH_VER_LF: begin
        if (is_lf) phase_d = PH_HDR_START;
      end
      PH_HDR_START: begin
        if (is_cr) begin
          kpos_d  = '0;
          kok_d   = 1'b0;
          phase_d = PH_HDRS_LF;
        end else if (b == CH_COLON) begin
          // Empty key never matches
          kpos_d  = '0;
          kok_d   = 1'b0;
          phase_d = PH_HKEY_SP;
        end else begin
          kpos_d  = key_hit0 ? 4'd1 : 4'd0;
          kok_d   = key_hit0;
          phase_d = PH_HKEY;
        end
      end
      PH_HKEY: begin
        if (b == CH_COLON) begin
          kok_d   = key_end_ok;
          kpos_d  = '0;
          phase_d = PH_HKEY_SP;
          if (key_end_ok) begin
            len_d  = '0;
            seen_d = 1'b0;
            bad_d  = 1'b0;
          end
        end else if (key_hit) begin
          kpos_d = cur_kpos + 4'd1;
        end else begin
          kok_d = 1'b0;
        end
      end
      PH_HKEY_SP: begin
        if (is_sp) phase_d = PH_HVAL;
      end
      PH_HVAL: begin
        if (is_cr) begin
          kok_d   = 1'b0;
          phase_d = PH_HVAL_LF;
        end else if (cur_kok && !cur_bad) begin
          // Length value text
          if (is_digit) begin
            seen_d = 1'b1;
            if (len_over) begin
              bad_d = 1'b1;
              len_d = '1;
            end else begin
              len_d = len_next[LENGTH_BITS-1:0];
            end
          end else if (!((is_sp || b == CH_TAB) && !cur_seen)) begin
            bad_d = 1'b1;
          end
        end
      end
      PH_HVAL_LF: begin
        if (is_lf) phase_d = PH_HDR_START;
      end
      PH_HDRS_LF: begin
        if (status == ST_DONE) phase_d = PH_DONE;
        else if (!err) begin
          bcnt_d  = '0;
          phase_d = PH_BODY;
        end
      end
      PH_BODY: begin
        bcnt_d = bcnt_inc;
        if (body_end) phase_d = PH_DONE;
      end
      default: begin
        phase_d = PH_ERROR;
      end
    endcase
    if (err) phase_d = PH_ERROR;
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      mpos_q  <= '0;
      get_q   <= 1'b0;
      kpos_q  <= '0;
      kok_q   <= 1'b0;
      len_q   <= '0;
      seen_q  <= 1'b0;
      bad_q   <= 1'b0;
      bcnt_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      mpos_q  <= mpos_d;
      get_q   <= get_d;
      kpos_q  <= kpos_d;
      kok_q   <= kok_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      bad_q   <= bad_d;
      bcnt_q  <= bcnt_d;
    end
  end

  // Length limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_byte_q <= b;
      out_cls_q  <= cls;
      out_st_q   <= status;
      out_get_q  <= get_d;
      out_len_q  <= len_d;
    end
  end

  // Output packing
  always_comb begin
    m_axis_tdata                   = '0;
    m_axis_tdata[7:0]              = out_byte_q;
    m_axis_tdata[9:8]              = out_st_q;
    m_axis_tdata[10]               = out_get_q;
    m_axis_tdata[11 +: LENGTH_BITS] = out_len_q;
  end
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_cls_q;

  // An error result always carries the delimiter class
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_st_q == ST_ERR) |-> (out_cls_q == CLS_DELIM))
    else $error("error result with non-delimiter class");

  // Error state is sticky until start_new
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !s_axis_tuser[0] && phase_q == PH_ERROR) |=> (out_st_q == ST_ERR))
    else $error("byte after error not reported as error");

  // While in the body the count stays below the declared length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (bcnt_q < len_q))
    else $error("body count reached declared length without completing");

  // A byte is always taken when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q) |-> s_axis_tready)
    else $error("input stalled with empty output register");

endmodule
